// ===== rtl/core/ecmb_pkg.sv =====
// ecmb_pkg: shared constants and types for the host mailbox port
// no dependencies; imported by ec_ram_mailbox_port and tb_top
`timescale 1ns / 1ps
`default_nettype none

package ecmb_pkg;

    // ram geometry
    localparam int ADDR_BITS = 11;
    localparam int RAM_DEPTH = 1 << ADDR_BITS;

    // command codes on the command/status port
    localparam logic [7:0] CMD_SET_HIGH = 8'hA3;
    localparam logic [7:0] CMD_SET_LOW  = 8'hA2;
    localparam logic [7:0] CMD_LOAD     = 8'hA4;
    localparam logic [7:0] CMD_STORE    = 8'hA5;

    // bus access kinds and port selects
    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;
    localparam logic PORT_DATA = 1'b0;
    localparam logic PORT_CMD  = 1'b1;

    // armed operation for the next data-port write
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_HIGH  = 2'd1,
        OP_LOW   = 2'd2,
        OP_STORE = 2'd3
    } op_t;

endpackage

`default_nettype wire

// ===== rtl/core/ec_ram_mailbox_port.sv =====
// ec_ram_mailbox_port: device side of a host mailbox in front of a byte ram
// depends on ecmb_pkg
`timescale 1ns / 1ps
`default_nettype none

// Takes one host bus request per clock while s_tready is high and returns one
// result byte per request. Requests go into an input register, are decoded in
// one pass against the address, armed-op and output-buffer registers, and the
// result lands in an output register, so a stalled result side still lets one
// more request in. The ram is a single-port 2048 x 8 array with a registered
// read; a load command reads it into the ram read register and the byte then
// passes into the output buffer, bypassed to any data read that follows at
// once. After reset a clearing pass zeroes all RAM_DEPTH (2048) entries, one
// entry per cycle; s_tready stays low until the pass is done.
module ec_ram_mailbox_port
    import ecmb_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    // request channel
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,   // [7:0] write_data
    input  wire  [1:0] s_tuser,   // [0] command, [1] port_sel
    // result channel
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata    // [7:0] read_data
);

    // input register
    logic                 in_valid_reg;
    logic                 in_cmd_reg;
    logic                 in_port_reg;
    logic [7:0]           in_byte_reg;

    // mailbox state
    logic [7:0]           addr_high_reg, addr_high_next;
    logic [7:0]           addr_low_reg, addr_low_next;
    op_t                  pending_op_reg, pending_op_next;
    logic [7:0]           out_buffer_reg;
    logic                 out_full_reg, out_full_next;
    logic                 ld_pend_reg, ld_pend_next;

    // result register
    logic                 m_valid_reg;
    logic [7:0]           m_data_reg;

    // ram and clearing pass
    logic [7:0]           ram [RAM_DEPTH];
    logic [7:0]           ram_rd_reg;
    logic                 clearing_reg;
    logic [ADDR_BITS-1:0] clr_cnt_reg;

    logic                 proc_fire;
    logic                 s_fire;
    logic [15:0]          addr_full;
    logic [ADDR_BITS-1:0] addr_cur;
    logic [ADDR_BITS-1:0] ram_waddr;
    logic [7:0]           ram_wdata;
    logic                 ram_we;
    logic                 ram_re;
    logic [7:0]           buf_now;
    logic [7:0]           result;

    // handshakes
    assign proc_fire = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !clearing_reg && (!in_valid_reg || proc_fire);
    assign s_fire    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign addr_full = {addr_high_reg, addr_low_reg};
    assign addr_cur  = addr_full[ADDR_BITS-1:0];

    // output buffer with bypass of a load still in flight
    assign buf_now = ld_pend_reg ? ram_rd_reg : out_buffer_reg;

    // request decode
    always_comb begin
        addr_high_next  = addr_high_reg;
        addr_low_next   = addr_low_reg;
        pending_op_next = pending_op_reg;
        out_full_next   = out_full_reg;
        ld_pend_next    = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        result          = 8'h00;
        if (proc_fire) begin
            if (in_cmd_reg == ACC_WRITE) begin
                if (in_port_reg == PORT_CMD) begin
                    case (in_byte_reg)
                        CMD_SET_HIGH: pending_op_next = OP_HIGH;
                        CMD_SET_LOW:  pending_op_next = OP_LOW;
                        CMD_STORE:    pending_op_next = OP_STORE;
                        CMD_LOAD: begin
                            ram_re          = 1'b1;
                            ld_pend_next    = 1'b1;
                            out_full_next   = 1'b1;
                            pending_op_next = OP_NONE;
                        end
                        default: ;
                    endcase
                end else begin
                    case (pending_op_reg)
                        OP_HIGH:  addr_high_next = in_byte_reg;
                        OP_LOW:   addr_low_next  = in_byte_reg;
                        OP_STORE: ram_we         = 1'b1;
                        default: ;
                    endcase
                    pending_op_next = OP_NONE;
                end
            end else if (in_port_reg == PORT_CMD) begin
                result = {7'd0, out_full_reg};
            end else begin
                result        = buf_now;
                out_full_next = 1'b0;
            end
        end
    end

    // ram write port: clearing pass or store
    assign ram_waddr = clearing_reg ? clr_cnt_reg : addr_cur;
    assign ram_wdata = clearing_reg ? 8'h00 : in_byte_reg;

    // ram array with registered read
    always_ff @(posedge aclk) begin
        if (clearing_reg || ram_we) begin
            ram[ram_waddr] <= ram_wdata;
        end
        if (ram_re) begin
            ram_rd_reg <= ram[addr_cur];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            addr_high_reg  <= 8'h00;
            addr_low_reg   <= 8'h00;
            pending_op_reg <= OP_NONE;
            out_buffer_reg <= 8'h00;
            out_full_reg   <= 1'b0;
            ld_pend_reg    <= 1'b0;
            clearing_reg   <= 1'b1;
            clr_cnt_reg    <= '0;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (proc_fire) begin
                in_valid_reg <= 1'b0;
            end
            if (proc_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            addr_high_reg  <= addr_high_next;
            addr_low_reg   <= addr_low_next;
            pending_op_reg <= pending_op_next;
            out_full_reg   <= out_full_next;
            ld_pend_reg    <= ld_pend_next;
            // commit a finished load into the buffer
            if (ld_pend_reg) begin
                out_buffer_reg <= ram_rd_reg;
            end
            // clearing pass after reset
            if (clearing_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg) begin
                    clearing_reg <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_cmd_reg  <= s_tuser[0];
            in_port_reg <= s_tuser[1];
            in_byte_reg <= s_tdata;
        end
        if (proc_fire) begin
            m_data_reg <= result;
        end
    end

    // checks
    a_write_gives_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && in_cmd_reg == ACC_WRITE |=> m_data_reg == 8'h00)
        else $error("write request produced a nonzero result");

    a_status_upper_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && in_cmd_reg == ACC_READ && in_port_reg == PORT_CMD
        |=> m_data_reg[7:1] == 7'd0)
        else $error("status read has upper bits set");

    a_data_write_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && in_cmd_reg == ACC_WRITE && in_port_reg == PORT_DATA
        |=> pending_op_reg == OP_NONE)
        else $error("data write left an operation armed");

    a_no_request_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !s_tready && !in_valid_reg)
        else $error("request taken during ram clearing");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for the host mailbox port ec_ram_mailbox_port
// drives host bus requests, predicts every result byte and checks it in order
// depends on ecmb_pkg and ec_ram_mailbox_port
`timescale 1ns / 1ps

module tb_top;
    import ecmb_pkg::*;

    localparam int CLK_HALF   = 5;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 20;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] write_data
    logic [1:0] s_tuser = 2'b00;   // [0] command, [1] port_sel
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] read_data

    // mirror of the mailbox state
    logic [7:0] mb_addr_hi;
    logic [7:0] mb_addr_lo;
    op_t        mb_armed;
    logic [7:0] mb_out_buf;
    logic       mb_out_full;
    logic [7:0] mb_ram [RAM_DEPTH];

    logic [7:0] pending_read_data [$];

    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    bit rx_hold_req = 1'b0;
    int sent_count = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    ec_ram_mailbox_port dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result byte a request yields, updating the mirrored state
    function automatic logic [7:0] predict_read_data(logic acc, logic port, logic [7:0] wbyte);
        logic [7:0]           result;
        logic [ADDR_BITS-1:0] ram_addr;
        result = 8'h00;
        ram_addr = ADDR_BITS'({mb_addr_hi, mb_addr_lo});
        if (acc == ACC_WRITE) begin
            if (port == PORT_CMD) begin
                case (wbyte)
                    CMD_SET_HIGH: mb_armed = OP_HIGH;
                    CMD_SET_LOW:  mb_armed = OP_LOW;
                    CMD_STORE:    mb_armed = OP_STORE;
                    CMD_LOAD: begin
                        mb_out_buf  = mb_ram[ram_addr];
                        mb_out_full = 1'b1;
                        mb_armed    = OP_NONE;
                    end
                    default: ;
                endcase
            end else begin
                case (mb_armed)
                    OP_HIGH:  mb_addr_hi = wbyte;
                    OP_LOW:   mb_addr_lo = wbyte;
                    OP_STORE: mb_ram[ram_addr] = wbyte;
                    default:  ;
                endcase
                mb_armed = OP_NONE;
            end
        end else if (port == PORT_CMD) begin
            result = {7'b0, mb_out_full};
        end else begin
            result = mb_out_buf;
            mb_out_full = 1'b0;
        end
        return result;
    endfunction

    // offer one request and wait until it is taken; valid stays high afterwards
    task automatic send_access(input logic acc, input logic port, input logic [7:0] wbyte);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= wbyte;
        s_tuser  <= {port, acc};
        do @(posedge aclk); while (!s_tready);
        pending_read_data.push_back(predict_read_data(acc, port, wbyte));
        sent_count++;
    endtask

    task automatic wr_cmd(input logic [7:0] code);
        send_access(ACC_WRITE, PORT_CMD, code);
    endtask

    task automatic wr_data(input logic [7:0] val);
        send_access(ACC_WRITE, PORT_DATA, val);
    endtask

    task automatic rd_status();
        send_access(ACC_READ, PORT_CMD, 8'h00);
    endtask

    task automatic rd_data();
        send_access(ACC_READ, PORT_DATA, 8'h00);
    endtask

    // result side: random stalls and one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 12)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_read_data.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %02h", $time, m_tdata);
                mismatch_count++;
            end else begin
                if (m_tdata !== pending_read_data[0]) begin
                    $display("%0t: read_data mismatch, expected %02h, actual %02h",
                             $time, pending_read_data[0], m_tdata);
                    mismatch_count++;
                end
                void'(pending_read_data.pop_front());
            end
        end
    end

    // fresh state: empty buffer, cleared ram
    task automatic test_after_reset();
        rd_status();
        rd_data();
        wr_cmd(CMD_LOAD);
        rd_status();
        rd_data();
    endtask

    // top address with ignored high bits, all-ones data, empty data read
    task automatic test_store_and_load();
        wr_cmd(CMD_SET_HIGH);
        wr_data(8'hFF);
        wr_cmd(CMD_SET_LOW);
        wr_data(8'hFF);
        wr_cmd(CMD_STORE);
        wr_data(8'hFF);
        wr_cmd(CMD_LOAD);
        rd_status();
        rd_data();
        rd_status();
        rd_data();
    endtask

    // unknown code keeps the armed op, rearm replaces, load disarms, load over full
    task automatic test_armed_op_cases();
        wr_cmd(CMD_SET_HIGH);
        wr_cmd(8'h00);
        wr_data(8'h00);
        wr_cmd(CMD_SET_HIGH);
        wr_cmd(CMD_SET_LOW);
        wr_data(8'h5A);
        wr_cmd(CMD_STORE);
        wr_cmd(CMD_LOAD);
        wr_data(8'hC3);
        wr_cmd(CMD_LOAD);
        rd_data();
    endtask

    // receiver holds off while requests keep coming
    task automatic test_rx_hold_off();
        rx_hold_req = 1'b1;
        repeat (10) begin
            wr_cmd(CMD_STORE);
            wr_data(8'($urandom_range(0, 255)));
            wr_cmd(CMD_LOAD);
            rd_data();
        end
    endtask

    // mostly well-formed command sequences, some noise and broken sequences
    task automatic test_random_traffic(input int n_items);
        int         stop_at;
        int         pick;
        logic [7:0] codes [4];
        codes = '{CMD_SET_HIGH, CMD_SET_LOW, CMD_LOAD, CMD_STORE};
        stop_at = sent_count + n_items;
        while (sent_count < stop_at) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1: begin
                    wr_cmd(CMD_SET_HIGH);
                    wr_data(8'($urandom_range(0, 255)));
                    wr_cmd(CMD_SET_LOW);
                    if ($urandom_range(0, 3) == 0)
                        wr_data(8'($urandom_range(0, 255)));
                    else
                        wr_data(8'($urandom_range(0, 3)));
                end
                2, 3: begin
                    wr_cmd(CMD_STORE);
                    wr_data(8'($urandom_range(0, 255)));
                end
                4, 5: begin
                    wr_cmd(CMD_LOAD);
                    rd_status();
                    rd_data();
                end
                6: rd_status();
                7: rd_data();
                8: send_access(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               8'($urandom_range(0, 255)));
                default: begin
                    wr_cmd(codes[$urandom_range(0, 3)]);
                    if ($urandom_range(0, 1) == 0)
                        wr_cmd(codes[$urandom_range(0, 3)]);
                    else
                        wr_cmd(8'($urandom_range(0, 255)));
                    wr_data(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    // main sequence
    initial begin
        mb_addr_hi  = 8'h00;
        mb_addr_lo  = 8'h00;
        mb_armed    = OP_NONE;
        mb_out_buf  = 8'h00;
        mb_out_full = 1'b0;
        foreach (mb_ram[i]) mb_ram[i] = 8'h00;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_after_reset();
        test_store_and_load();
        test_armed_op_cases();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_random_traffic(450);
        tx_idle_on = 1'b0;
        test_rx_hold_off();
        tx_idle_on = 1'b1;
        test_random_traffic(450);
        // last stretch at full rate
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_traffic(100);

        s_tvalid <= 1'b0;
        while (pending_read_data.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_read_data.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ecmb_pkg.sv
rtl/core/ec_ram_mailbox_port.sv
dv/tb_top.sv
